FILE: rtl/frame_deframer_crc8_macros.svh
// ----------------------------------------------------------------------------
// frame_deframer_crc8 assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_DEFRAMER_CRC8_MACROS_SVH
`define FRAME_DEFRAMER_CRC8_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define FDC8_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define FDC8_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FDC8_ASSERT_IMP(lbl, ante, cons)
`define FDC8_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/fdc8_pkg.sv
// ----------------------------------------------------------------------------
// fdc8_pkg
// Types, constants and the CRC-8 step shared by the deframer modules.
// ----------------------------------------------------------------------------
package fdc8_pkg;

    localparam int HDR_BYTES = 16;
    localparam int HDR_IDX_W = $clog2(HDR_BYTES);
    localparam int POS_W     = 17;

    // Header byte offsets
    localparam int OFS_MAGIC = 0;
    localparam int OFS_FLAGS = 2;
    localparam int OFS_TS    = 4;
    localparam int OFS_SEQ   = 8;
    localparam int OFS_LEN   = 10;
    localparam int OFS_CRC   = 12;

    localparam logic [7:0] CRC_POLY_REFL = 8'hAB;

    // Configuration register indexes
    localparam logic [1:0] REG_MAGIC_CODE      = 2'd0;
    localparam logic [1:0] REG_CRC_FLAG_MASK   = 2'd1;
    localparam logic [1:0] REG_CRC_INITIAL     = 2'd2;
    localparam logic [1:0] REG_WIRE_BIG_ENDIAN = 2'd3;

    typedef struct packed {
        logic [15:0] magic_code;
        logic [15:0] crc_flag_mask;
        logic [7:0]  crc_initial;
        logic        wire_big_endian;
    } t_cfg;

    typedef struct packed {
        logic [15:0] frame_flags;
        logic [31:0] frame_timestamp;
        logic [15:0] frame_sequence;
        logic [15:0] frame_length;
        logic [7:0]  payload_byte;
        logic        bad_magic;
        logic        crc_error;
        logic        payload_valid;
        logic        frame_last;
    } t_result;

    // One byte through the reflected CRC-8 register
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/fdc8_parse.sv
// ----------------------------------------------------------------------------
// fdc8_parse
// Per-byte frame parser: header capture, field decode, CRC and end of frame.
// ----------------------------------------------------------------------------
`include "frame_deframer_crc8_macros.svh"

module fdc8_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fdc8_pkg::t_cfg    i_cfg,
    input  logic              i_acc,
    input  logic [7:0]        i_byte,
    input  logic              i_chunk_end,
    output logic              o_res_valid,
    output fdc8_pkg::t_result o_res
);

    logic [fdc8_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                 r_crc, n_crc;
    logic                       r_discard, n_discard;
    logic [7:0]                 r_hdr [fdc8_pkg::HDR_BYTES];

    logic [15:0] w_magic, w_flags, w_seq, w_len;
    logic [31:0] w_ts;
    logic        w_in_hdr;
    logic        w_hdr_done;
    logic        w_crc_en;
    logic [7:0]  w_crc_upd;
    logic [fdc8_pkg::POS_W-1:0] w_pos_inc;
    logic [fdc8_pkg::POS_W-1:0] w_frame_end;

    // Decode header fields in the configured byte order
    always_comb begin
        if (i_cfg.wire_big_endian) begin
            w_magic = {r_hdr[fdc8_pkg::OFS_MAGIC], r_hdr[fdc8_pkg::OFS_MAGIC+1]};
            w_flags = {r_hdr[fdc8_pkg::OFS_FLAGS], r_hdr[fdc8_pkg::OFS_FLAGS+1]};
            w_ts    = {r_hdr[fdc8_pkg::OFS_TS],   r_hdr[fdc8_pkg::OFS_TS+1],
                       r_hdr[fdc8_pkg::OFS_TS+2], r_hdr[fdc8_pkg::OFS_TS+3]};
            w_seq   = {r_hdr[fdc8_pkg::OFS_SEQ], r_hdr[fdc8_pkg::OFS_SEQ+1]};
            w_len   = {r_hdr[fdc8_pkg::OFS_LEN], r_hdr[fdc8_pkg::OFS_LEN+1]};
        end else begin
            w_magic = {r_hdr[fdc8_pkg::OFS_MAGIC+1], r_hdr[fdc8_pkg::OFS_MAGIC]};
            w_flags = {r_hdr[fdc8_pkg::OFS_FLAGS+1], r_hdr[fdc8_pkg::OFS_FLAGS]};
            w_ts    = {r_hdr[fdc8_pkg::OFS_TS+3], r_hdr[fdc8_pkg::OFS_TS+2],
                       r_hdr[fdc8_pkg::OFS_TS+1], r_hdr[fdc8_pkg::OFS_TS]};
            w_seq   = {r_hdr[fdc8_pkg::OFS_SEQ+1], r_hdr[fdc8_pkg::OFS_SEQ]};
            w_len   = {r_hdr[fdc8_pkg::OFS_LEN+1], r_hdr[fdc8_pkg::OFS_LEN]};
        end
    end

    assign w_in_hdr    = (r_pos < fdc8_pkg::POS_W'(fdc8_pkg::HDR_BYTES));
    assign w_hdr_done  = (r_pos == fdc8_pkg::POS_W'(fdc8_pkg::HDR_BYTES - 1));
    assign w_crc_en    = ((w_flags & i_cfg.crc_flag_mask) != 16'd0);
    assign w_crc_upd   = fdc8_pkg::crc8_update(r_crc, i_byte);
    assign w_pos_inc   = r_pos + 1'b1;
    assign w_frame_end = fdc8_pkg::POS_W'(w_len) + fdc8_pkg::POS_W'(fdc8_pkg::HDR_BYTES);

    // Next state and result for one accepted byte
    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_discard   = r_discard;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.frame_flags     = w_flags;
        o_res.frame_timestamp = w_ts;
        o_res.frame_sequence  = w_seq;
        o_res.frame_length    = w_len;
        if (i_acc) begin
            if (r_discard) begin
                // drop bytes up to the chunk end
                if (i_chunk_end) begin
                    n_discard = 1'b0;
                end
            end else if (w_in_hdr) begin
                n_pos = w_pos_inc;
                if (w_hdr_done) begin
                    if (w_magic != i_cfg.magic_code) begin
                        o_res_valid     = 1'b1;
                        o_res.bad_magic = 1'b1;
                        n_pos           = '0;
                        n_discard       = !i_chunk_end;
                    end else begin
                        n_crc = i_cfg.crc_initial;
                        if (w_len == 16'd0) begin
                            o_res_valid      = 1'b1;
                            o_res.frame_last = 1'b1;
                            o_res.crc_error  = w_crc_en &&
                                               (i_cfg.crc_initial != r_hdr[fdc8_pkg::OFS_CRC]);
                            n_pos            = '0;
                        end
                    end
                end
            end else begin
                // payload byte: pass on and advance the CRC
                n_crc               = w_crc_upd;
                n_pos               = w_pos_inc;
                o_res_valid         = 1'b1;
                o_res.payload_valid = 1'b1;
                o_res.payload_byte  = i_byte;
                if (w_pos_inc >= w_frame_end) begin
                    o_res.frame_last = 1'b1;
                    o_res.crc_error  = w_crc_en && (w_crc_upd != r_hdr[fdc8_pkg::OFS_CRC]);
                    n_pos            = '0;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_crc     <= '0;
            r_discard <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_discard <= n_discard;
        end
    end

    // Capture header bytes
    always_ff @(posedge i_clk) begin
        if (i_acc && !r_discard && w_in_hdr) begin
            r_hdr[r_pos[fdc8_pkg::HDR_IDX_W-1:0]] <= i_byte;
        end
    end

    `FDC8_ASSERT_IMP(a_discard_silent, i_acc && r_discard, !o_res_valid)
    `FDC8_ASSERT_IMP(a_discard_at_start, r_discard, r_pos == '0)
    `FDC8_ASSERT_IMP(a_bad_magic_kind, o_res_valid && o_res.bad_magic,
                     !o_res.frame_last && !o_res.payload_valid && !o_res.crc_error)
    `FDC8_ASSERT_IMP(a_pos_in_frame, !w_in_hdr, r_pos < w_frame_end)

endmodule

FILE: rtl/fdc8_skid.sv
// ----------------------------------------------------------------------------
// fdc8_skid
// Output register with one skid entry so the parser keeps taking bytes
// while a result waits on the downstream side.
// ----------------------------------------------------------------------------
`include "frame_deframer_crc8_macros.svh"

module fdc8_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fdc8_pkg::t_result i_res,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output fdc8_pkg::t_result o_res
);

    logic              r_out_valid, r_skid_valid;
    fdc8_pkg::t_result r_out, r_skid;
    logic              w_pop;

    assign w_pop   = r_out_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_push) begin
                r_out <= i_res;
            end
        end else if (i_push) begin
            if (r_out_valid) begin
                r_skid <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

    `FDC8_ASSERT_IMP(a_skid_behind_out, r_skid_valid, r_out_valid)
    `FDC8_ASSERT_NXT(a_skid_drains, r_skid_valid && w_pop, r_out_valid && !r_skid_valid)

endmodule

FILE: rtl/frame_deframer_crc8.sv
// ----------------------------------------------------------------------------
// frame_deframer_crc8
// Byte-serial deframer for magic/length frames with a payload CRC-8 check.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one received byte per transaction, s_tlast marks the last
//   byte of a received chunk. Frames are a 16-byte header and a payload.
//   m_* carries one result per payload byte, one per zero-length frame and
//   one per header with a wrong magic; m_tlast marks the end of a frame.
//   i_cfg_* writes the registers (magic, CRC flag mask, CRC seed, byte
//   order) while no frame is in flight; o_cfg_ready is always high.
// Throughput: one byte per cycle while s_tready is high; the byte parser and CRC-8
//   step update in the same cycle the byte is taken.
// Output: each result is registered, in the output register or the skid entry.
// Stall: a one-entry skid behind the output register absorbs one result;
//   s_tready drops only while both hold data.
// Reset: parser returns to the frame start, discard mode clears, output
//   empties and the registers take their reset values.
// ----------------------------------------------------------------------------
module frame_deframer_crc8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // chunk_end
    // results out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [7:0] payload_byte, [23:8] frame_length,
                                   // [39:24] frame_sequence, [71:40] frame_timestamp,
                                   // [87:72] frame_flags
    output logic        m_tlast,   // frame_last
    output logic [2:0]  m_tuser,   // [0] payload_valid, [1] crc_error, [2] bad_magic
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    fdc8_pkg::t_cfg    r_cfg;
    fdc8_pkg::t_result w_res, w_out;
    logic              w_res_valid;
    logic              w_space;
    logic              w_acc;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = w_space;
    assign w_acc       = s_tvalid && w_space;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_code      <= 16'd0;
            r_cfg.crc_flag_mask   <= 16'd1;
            r_cfg.crc_initial     <= 8'd0;
            r_cfg.wire_big_endian <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fdc8_pkg::REG_MAGIC_CODE:      r_cfg.magic_code      <= i_cfg_data;
                fdc8_pkg::REG_CRC_FLAG_MASK:   r_cfg.crc_flag_mask   <= i_cfg_data;
                fdc8_pkg::REG_CRC_INITIAL:     r_cfg.crc_initial     <= i_cfg_data[7:0];
                fdc8_pkg::REG_WIRE_BIG_ENDIAN: r_cfg.wire_big_endian <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    fdc8_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_acc       (w_acc),
        .i_byte      (s_tdata),
        .i_chunk_end (s_tlast),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    fdc8_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_space (w_space),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_res   (w_out)
    );

    // Pack the result onto the stream
    assign m_tdata = {w_out.frame_flags, w_out.frame_timestamp, w_out.frame_sequence,
                      w_out.frame_length, w_out.payload_byte};
    assign m_tlast = w_out.frame_last;
    assign m_tuser = {w_out.bad_magic, w_out.crc_error, w_out.payload_valid};

endmodule
